[hw/rtl/ttv_pkg.sv]
package ttv_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } t_vtx;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic        [1:0]  corner;
        logic               last;
        logic               degenerate;
    } t_tan;

    localparam int NORM_BITS   = 30;
    localparam int MAG_W       = 66;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 47;
    localparam int TRI_CORNERS = 3;

    typedef struct packed {
        logic hold;
        logic load3;
        logic mul_start;
        logic norm_start;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic div_store;
        logic [1:0] div_sel;
    } t_cmd;

    typedef struct packed {
        logic degen;
    } t_sts;

endpackage

[hw/rtl/ttv_datapath.sv]
module ttv_datapath (
    input  logic          i_clk,
    input  ttv_pkg::t_vtx i_vtx,
    input  logic          i_slot,
    input  ttv_pkg::t_cmd i_cmd,
    input  logic [5:0]    i_mul_idx,
    output ttv_pkg::t_sts o_sts,
    output logic signed [15:0] o_comp [3]
);
    import ttv_pkg::*;

    logic signed [31:0] r_p0 [3];
    logic signed [31:0] r_p1 [3];
    logic signed [31:0] r_p2 [3];
    logic signed [31:0] r_uv0 [2];
    logic signed [31:0] r_uv1 [2];
    logic signed [31:0] r_uv2 [2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) begin
            if (!i_slot) begin
                r_p0[0] <= i_vtx.pos_x; r_p0[1] <= i_vtx.pos_y; r_p0[2] <= i_vtx.pos_z;
                r_uv0[0] <= i_vtx.tex_u; r_uv0[1] <= i_vtx.tex_v;
            end else begin
                r_p1[0] <= i_vtx.pos_x; r_p1[1] <= i_vtx.pos_y; r_p1[2] <= i_vtx.pos_z;
                r_uv1[0] <= i_vtx.tex_u; r_uv1[1] <= i_vtx.tex_v;
            end
        end
        if (i_cmd.load3) begin
            r_p2[0] <= i_vtx.pos_x; r_p2[1] <= i_vtx.pos_y; r_p2[2] <= i_vtx.pos_z;
            r_uv2[0] <= i_vtx.tex_u; r_uv2[1] <= i_vtx.tex_v;
        end
    end

    // Deltas, 33 bit signed.
    logic signed [32:0] w_du1, w_dv1, w_du2, w_dv2;
    logic signed [32:0] w_e1 [3];
    logic signed [32:0] w_e2 [3];
    always_comb begin
        w_du1 = 33'(r_uv1[0]) - 33'(r_uv0[0]);
        w_dv1 = 33'(r_uv1[1]) - 33'(r_uv0[1]);
        w_du2 = 33'(r_uv2[0]) - 33'(r_uv0[0]);
        w_dv2 = 33'(r_uv2[1]) - 33'(r_uv0[1]);
        for (int i = 0; i < 3; i++) begin
            w_e1[i] = 33'(r_p1[i]) - 33'(r_p0[i]);
            w_e2[i] = 33'(r_p2[i]) - 33'(r_p0[i]);
        end
    end

    // Products: 8 of 33x33, each split into four 16x16 partial steps on the magnitudes.
    // Product index p in 0..7: det a, det b, then a,b for each component.
    logic [2:0] w_pi;
    logic [1:0] w_part;
    assign w_pi   = i_mul_idx[4:2];
    assign w_part = i_mul_idx[1:0];

    logic signed [32:0] w_ma, w_mb;
    always_comb begin
        unique case (w_pi)
            3'd0: begin w_ma = w_du1; w_mb = w_dv2; end
            3'd1: begin w_ma = w_du2; w_mb = w_dv1; end
            3'd2: begin w_ma = w_dv2; w_mb = w_e1[0]; end
            3'd3: begin w_ma = w_dv1; w_mb = w_e2[0]; end
            3'd4: begin w_ma = w_dv2; w_mb = w_e1[1]; end
            3'd5: begin w_ma = w_dv1; w_mb = w_e2[1]; end
            3'd6: begin w_ma = w_dv2; w_mb = w_e1[2]; end
            default: begin w_ma = w_dv1; w_mb = w_e2[2]; end
        endcase
    end

    logic [31:0] w_aa, w_ab;
    logic        w_na, w_nb;
    assign w_na = w_ma[32];
    assign w_nb = w_mb[32];
    assign w_aa = w_na ? 32'(-w_ma) : w_ma[31:0];
    assign w_ab = w_nb ? 32'(-w_mb) : w_mb[31:0];

    logic [15:0] w_ha, w_hb;
    assign w_ha = w_part[1] ? w_aa[31:16] : w_aa[15:0];
    assign w_hb = w_part[0] ? w_ab[31:16] : w_ab[15:0];

    logic [31:0] r_pp;
    logic [1:0]  r_pp_part;
    logic [2:0]  r_pp_pi;
    logic        r_pp_v;
    logic        r_pp_neg;
    always_ff @(posedge i_clk) begin
        r_pp      <= w_ha * w_hb;
        r_pp_part <= w_part;
        r_pp_pi   <= w_pi;
        r_pp_neg  <= w_na ^ w_nb;
        r_pp_v    <= i_cmd.mul_start;
    end

    logic [63:0] r_acc;
    logic [63:0] r_prod [8];
    logic        r_pneg [8];
    logic [63:0] w_acc_next;
    always_comb begin
        unique case (r_pp_part)
            2'd0: w_acc_next = 64'(r_pp);
            2'd1, 2'd2: w_acc_next = r_acc + {16'd0, r_pp, 16'd0};
            default: w_acc_next = r_acc + {r_pp, 32'd0};
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (r_pp_v) begin
            r_acc <= w_acc_next;
            if (r_pp_part == 2'd3) begin
                r_prod[r_pp_pi] <= w_acc_next;
                r_pneg[r_pp_pi] <= r_pp_neg && (w_acc_next != 64'd0);
            end
        end
    end

    // Combine: one signed magnitude a - b per pair, issued at norm_start.
    function automatic logic [66:0] f_diff(input logic [63:0] m1, input logic n1,
                                           input logic [63:0] m2, input logic n2c);
        logic [64:0] s;
        logic        n;
        begin
            if (n1 == n2c) begin
                s = {1'b0, m1} + {1'b0, m2};
                n = n1;
            end else if (m1 >= m2) begin
                s = {1'b0, m1 - m2};
                n = n1;
            end else begin
                s = {1'b0, m2 - m1};
                n = n2c;
            end
            if (s == 65'd0) n = 1'b0;
            f_diff = {n, 1'b0, s};
        end
    endfunction

    logic [66:0] w_det, w_t [3];
    always_comb begin
        w_det = f_diff(r_prod[0], r_pneg[0], r_prod[1],
                       (r_prod[1] != 64'd0) && !r_pneg[1]);
        for (int i = 0; i < 3; i++) begin
            w_t[i] = f_diff(r_prod[2+2*i], r_pneg[2+2*i], r_prod[3+2*i],
                            (r_prod[3+2*i] != 64'd0) && !r_pneg[3+2*i]);
        end
    end

    logic [64:0] r_tm [3];
    logic        r_tn [3];
    logic        r_det_zero;
    logic        r_det_neg;
    logic        r_nvalid;
    always_ff @(posedge i_clk) begin
        r_nvalid <= i_cmd.norm_start;
        if (i_cmd.norm_start) begin
            r_det_zero <= (w_det[64:0] == 65'd0);
            r_det_neg  <= w_det[66];
            for (int i = 0; i < 3; i++) begin
                r_tm[i] <= w_t[i][64:0];
                r_tn[i] <= w_t[i][66];
            end
        end
    end

    // Shift to NORM_BITS and sign, registered in the cycle after the combine.
    logic [64:0] w_or;
    logic [6:0]  w_bl;
    logic [6:0]  w_sh;
    always_comb begin
        w_or = r_tm[0] | r_tm[1] | r_tm[2];
        w_bl = 7'd0;
        for (int b = 0; b < 65; b++) begin
            if (w_or[b]) w_bl = 7'(b + 1);
        end
        w_sh = (w_bl > 7'(NORM_BITS)) ? w_bl - 7'(NORM_BITS) : 7'd0;
    end

    logic [29:0] r_m [3];
    logic        r_neg [3];
    logic        r_degen;
    always_ff @(posedge i_clk) begin
        if (r_nvalid) begin
            r_degen <= r_det_zero || (w_bl == 7'd0);
            for (int i = 0; i < 3; i++) begin
                r_m[i]   <= 30'(r_tm[i] >> w_sh);
                r_neg[i] <= r_tn[i] ^ (r_det_neg && (r_tm[i] != 65'd0));
            end
        end
    end
    assign o_sts.degen = r_degen;

    // The three squares are summed in the sqrt step phase, before the root starts.
    logic [63:0] r_sum;
    logic [1:0]  r_sq_i;
    logic [59:0] r_sq;

    // Integer square root, one result bit per step.
    logic [31:0] r_root;
    logic [5:0]  r_sq_cnt;
    logic [65:0] r_part;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_part <= 66'd0;
            r_root <= 32'd0;
            r_sum  <= 64'd0;
            r_sq_i <= 2'd0;
        end else if (i_cmd.sqrt_step) begin
            if (r_sq_cnt < 6'd3) begin
                r_sq  <= r_m[r_sq_i] * r_m[r_sq_i];
                r_sq_i <= r_sq_i + 2'd1;
                if (r_sq_cnt != 6'd0) r_sum <= r_sum + 64'(r_sq);
            end else if (r_sq_cnt == 6'd3) begin
                r_sum <= r_sum + 64'(r_sq);
            end else begin
                if ({r_part[63:0], r_sum[63:62]} >= {r_root, 2'b01}) begin
                    r_part <= 66'({r_part[63:0], r_sum[63:62]} - 66'({r_root, 2'b01}));
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_part <= 66'({r_part[63:0], r_sum[63:62]});
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_sum <= {r_sum[61:0], 2'b00};
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) r_sq_cnt <= 6'd0;
        else if (i_cmd.sqrt_step) r_sq_cnt <= r_sq_cnt + 6'd1;
    end

    // Restoring divide: (m << 16) / len, 46-bit dividend.
    logic [31:0] w_len;
    assign w_len = (r_root == 32'd0) ? 32'd1 : r_root;

    logic [45:0] r_dq;
    logic [32:0] r_dr;
    logic [32:0] w_dr_sh;
    logic [32:0] w_dr_sub;
    always_comb begin
        w_dr_sh  = {r_dr[31:0], r_dq[45]};
        w_dr_sub = w_dr_sh - {1'b0, w_len};
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq <= {r_m[i_cmd.div_sel], 16'd0};
            r_dr <= 33'd0;
        end else if (i_cmd.div_step) begin
            if (!w_dr_sub[32]) begin
                r_dr <= w_dr_sub;
                r_dq <= {r_dq[44:0], 1'b1};
            end else begin
                r_dr <= w_dr_sh;
                r_dq <= {r_dq[44:0], 1'b0};
            end
        end
    end

    logic [46:0] w_q;
    logic [15:0] w_qs;
    always_comb begin
        w_q  = ({1'b0, r_dq} + 47'd1) >> 1;
        w_qs = (w_q > 47'd32767) ? 16'd32767 : w_q[15:0];
    end

    logic signed [15:0] r_comp [3];
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            if (r_degen) r_comp[i_cmd.div_sel] <= 16'sd0;
            else r_comp[i_cmd.div_sel] <= r_neg[i_cmd.div_sel] ? -w_qs : w_qs;
        end
    end
    assign o_comp = r_comp;
endmodule

[hw/rtl/ttv_ctrl.sv]
module ttv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_corner,
    output logic          o_slot,
    output logic [5:0]    o_mul_idx,
    output ttv_pkg::t_cmd o_cmd
);
    import ttv_pkg::*;

    typedef enum logic [6:0] {
        S_IN   = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_NORM = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic [5:0] r_step, n_step;
    logic [1:0] r_sel, n_sel;
    logic [1:0] r_corner, n_corner;

    logic w_acc;
    assign o_in_stall  = (r_state != S_IN);
    assign w_acc       = i_in_valid && (r_state == S_IN);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_corner    = r_corner;
    assign o_slot      = r_cnt[0];
    assign o_mul_idx   = r_step;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_step = r_step;
        n_sel = r_sel; n_corner = r_corner;
        o_cmd = '0;
        o_cmd.div_sel = r_sel;
        unique case (r_state)
            S_IN: begin
                if (w_acc) begin
                    if (r_cnt == 2'd2) begin
                        o_cmd.load3 = 1'b1;
                        n_cnt = 2'd0; n_step = 6'd0; n_state = S_MUL;
                    end else begin
                        o_cmd.hold = 1'b1;
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_start = (r_step < 6'd32);
                n_step = r_step + 6'd1;
                if (r_step == 6'd33) n_state = S_NORM;
            end
            S_NORM: begin
                n_step = r_step + 6'd1;
                if (r_step == 6'd34) o_cmd.norm_start = 1'b1;
                if (r_step == 6'd35) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_step = 6'd0; n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step + 6'd1;
                if (r_step == 6'(SQRT_STEPS + 3)) begin
                    n_step = 6'd0; n_sel = 2'd0; n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_step = r_step + 6'd1;
                if (r_step == 6'd0) o_cmd.div_start = 1'b1;
                else if (r_step <= 6'(DIV_STEPS - 1)) o_cmd.div_step = 1'b1;
                else begin
                    o_cmd.div_store = 1'b1;
                    n_step = 6'd0;
                    if (r_sel == 2'd2) begin
                        n_corner = 2'd0; n_state = S_EMIT;
                    end else n_sel = r_sel + 2'd1;
                end
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    if (r_corner == 2'(TRI_CORNERS - 1)) n_state = S_IN;
                    else n_corner = r_corner + 2'd1;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN; r_cnt <= 2'd0; r_step <= 6'd0;
            r_sel <= 2'd0; r_corner <= 2'd0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_step <= n_step;
            r_sel <= n_sel; r_corner <= n_corner;
        end
    end
endmodule

[hw/rtl/triangle_tangent_vector.sv]
// Channel | direction | handshake            | payload
// in      | input     | i_in_valid/o_in_stall | ttv_pkg::t_vtx, one vertex per beat
// out     | output    | o_out_valid/i_out_stall | ttv_pkg::t_tan, three beats per triangle
// The first two vertices are stored as they are accepted.
// After the third vertex come the partial products, the combine and scale, the squares
// and a 32-step root, and three divides in one shared restoring divider; then three
// result beats.
// Reset is synchronous and active low and clears the vertex count and the controller.
// Input is stalled from the third vertex until the last result beat is taken.
module triangle_tangent_vector #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ttv_pkg::t_vtx i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ttv_pkg::t_tan o_out_data
);
    import ttv_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic [1:0] w_corner;
    logic       w_slot;
    logic [5:0] w_mul_idx;
    logic signed [15:0] w_comp [3];

    ttv_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_corner(w_corner), .o_slot(w_slot), .o_mul_idx(w_mul_idx),
        .o_cmd(w_cmd)
    );

    ttv_datapath u_dp (
        .i_clk(i_clk), .i_vtx(i_in_data), .i_slot(w_slot), .i_cmd(w_cmd),
        .i_mul_idx(w_mul_idx), .o_sts(w_sts), .o_comp(w_comp)
    );

    always_comb begin
        o_out_data.tangent_x  = w_comp[0];
        o_out_data.tangent_y  = w_comp[1];
        o_out_data.tangent_z  = w_comp[2];
        o_out_data.corner     = w_corner;
        o_out_data.last       = (w_corner == 2'(TRI_CORNERS - 1));
        o_out_data.degenerate = w_sts.degen;
    end

    localparam int FRAC_CHECK = COORD_FRAC_BITS;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input open while emitting");
    a_corner_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed under stall");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.degenerate) |->
        (o_out_data.tangent_x == 16'sd0 && o_out_data.tangent_y == 16'sd0 &&
         o_out_data.tangent_z == 16'sd0))
        else $error("degenerate tangent not zero");
    a_frac: assert property (@(posedge i_clk)
        FRAC_CHECK >= 8 && FRAC_CHECK <= 24) else $error("fraction bits out of range");
endmodule
